### rtl/core/hcbd_pkg.sv
// Shared constants and helpers for the chunked transfer body decoder.
// Holds status codes, character codes, register reset values and the hex digit decode.
// Depends on nothing; imported by http_chunked_body_decoder_unit.
package hcbd_pkg;

  // Result status codes
  localparam logic [1:0] ST_RUN = 2'd0;
  localparam logic [1:0] ST_OK  = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;
  localparam logic [1:0] ST_BIG = 2'd3;

  // Character codes
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;

  // Configuration register indexes (word address bit 2)
  localparam logic REG_MAX_BODY = 1'b0;
  localparam logic REG_TRAILERS = 1'b1;

  // Register reset values
  localparam logic [31:0] MAX_BODY_RESET = 32'd1048576;
  localparam logic        TRAILERS_RESET = 1'b0;

  // Default number of significant size digits
  localparam int MAX_HEX_DIGITS_DEF = 8;

  // Hex digit decode: bit 4 flags a hex digit, bits 3:0 carry its value
  typedef logic [4:0] hex_dec_t;

  function automatic hex_dec_t hex_decode(input logic [7:0] c);
    hex_dec_t res;
    res = '0;
    if (c >= "0" && c <= "9") begin
      res = {1'b1, 4'(c - 8'h30)};
    end else if (c >= "a" && c <= "f") begin
      res = {1'b1, 4'(c - 8'h57)};
    end else if (c >= "A" && c <= "F") begin
      res = {1'b1, 4'(c - 8'h37)};
    end
    return res;
  endfunction

endpackage

### rtl/core/http_chunked_body_decoder_unit.sv
// Top level of the HTTP/1.1 chunked transfer body decoder.
// Parses size lines, passes data bytes, checks CRLF framing and the body size limit.
// Depends on hcbd_pkg.
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+---------------------------------------------
//  in_      | request   | in_valid/in_stall  | in_data_byte, in_new_message
//  out_     | result    | out_valid/out_stall| out_byte, out_body_valid, out_status,
//           |           |                    | out_body_length
//  config   | APB write | psel/penable/...   | max_body_size (0x0), trailers_allowed (0x4)
//
// One request per clock while out_stall does not hold the result, one result per request.
// The request register feeds the parse state and the result register directly; the
// parser state advances in the same cycle as the result register loads.
// When out_stall holds the result, one more request is taken into the request register.
// Reset (rst_n low, synchronous) clears the parser and sets the registers to defaults.
module http_chunked_body_decoder_unit
  import hcbd_pkg::*;
#(
  parameter int MAX_HEX_DIGITS = MAX_HEX_DIGITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_new_message,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_body_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_body_length,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Size held in 32 bits, so no more than eight significant digits
  localparam int DIGIT_LIMIT = (MAX_HEX_DIGITS > 8) ? 8 : MAX_HEX_DIGITS;
  localparam int DIGIT_W     = $clog2(DIGIT_LIMIT + 1);
  localparam logic [DIGIT_W-1:0] DIGIT_MAX = DIGIT_W'(DIGIT_LIMIT);

  // Parser phases
  localparam logic [3:0] PH_SIZE       = 4'd0;
  localparam logic [3:0] PH_EXT        = 4'd1;
  localparam logic [3:0] PH_EXT_LF     = 4'd2;
  localparam logic [3:0] PH_SIZE_LF    = 4'd3;
  localparam logic [3:0] PH_DATA       = 4'd4;
  localparam logic [3:0] PH_DATA_CR    = 4'd5;
  localparam logic [3:0] PH_DATA_LF    = 4'd6;
  localparam logic [3:0] PH_TRAILER    = 4'd7;
  localparam logic [3:0] PH_TRAILER_LF = 4'd8;
  localparam logic [3:0] PH_FINAL_CR   = 4'd9;
  localparam logic [3:0] PH_FINAL_LF   = 4'd10;
  localparam logic [3:0] PH_DONE       = 4'd11;

  // Configuration registers
  logic [31:0] max_body_r;
  logic        trailers_r;

  // Request register
  logic        req_valid_r;
  logic [7:0]  req_byte_r;
  logic        req_new_r;

  // Parser state
  logic [3:0]         phase_r,  phase_nxt;
  logic [31:0]        remain_r, remain_nxt;
  logic [DIGIT_W-1:0] digits_r, digits_nxt;
  logic [31:0]        count_r,  count_nxt;
  logic               empty_r,  empty_nxt;
  logic [1:0]         status_r, status_nxt;

  // Result register
  logic        out_valid_r;
  logic [7:0]  out_byte_r,   byte_nxt;
  logic        out_bvalid_r, bvalid_nxt;
  logic [1:0]  out_status_r;
  logic [31:0] out_len_r;

  // Effective state after an optional new-message clear
  logic [3:0]         cur_phase;
  logic [31:0]        cur_remain;
  logic [DIGIT_W-1:0] cur_digits;
  logic [31:0]        cur_count;
  logic               cur_empty;
  logic [1:0]         cur_status;

  hex_dec_t    hex;
  logic [31:0] remain_dec;
  logic        advance;
  logic        in_accept;
  logic        cfg_write;

  // Handshake: the request register moves on whenever the result register can take it
  assign advance   = req_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = req_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;
  assign cfg_write = psel && penable && pwrite && pready;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TRAILERS) ? {31'd0, trailers_r} : max_body_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_body_r <= MAX_BODY_RESET;
      trailers_r <= TRAILERS_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_MAX_BODY) begin
        max_body_r <= pwdata;
      end else begin
        trailers_r <= pwdata[0];
      end
    end
  end

  // Request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_accept) begin
      req_valid_r <= 1'b1;
    end else if (advance) begin
      req_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_byte_r <= in_data_byte;
      req_new_r  <= in_new_message;
    end
  end

  // New-message clear applied ahead of the byte
  always_comb begin
    if (req_new_r) begin
      cur_phase  = PH_SIZE;
      cur_remain = '0;
      cur_digits = '0;
      cur_count  = '0;
      cur_empty  = 1'b1;
      cur_status = ST_RUN;
    end else begin
      cur_phase  = phase_r;
      cur_remain = remain_r;
      cur_digits = digits_r;
      cur_count  = count_r;
      cur_empty  = empty_r;
      cur_status = status_r;
    end
  end

  assign hex        = hex_decode(req_byte_r);
  assign remain_dec = cur_remain - 32'd1;

  // Byte parser
  always_comb begin
    phase_nxt  = cur_phase;
    remain_nxt = cur_remain;
    digits_nxt = cur_digits;
    count_nxt  = cur_count;
    empty_nxt  = cur_empty;
    status_nxt = cur_status;
    byte_nxt   = 8'd0;
    bvalid_nxt = 1'b0;
    case (cur_phase)
      PH_SIZE: begin
        if (hex[4]) begin
          if (cur_remain == 32'd0 && hex[3:0] == 4'd0) begin
            // leading zero, not significant
            empty_nxt = 1'b0;
          end else if (cur_digits >= DIGIT_MAX) begin
            status_nxt = ST_BAD;
            phase_nxt  = PH_DONE;
          end else begin
            remain_nxt = {cur_remain[27:0], hex[3:0]};
            digits_nxt = cur_digits + DIGIT_W'(1);
            empty_nxt  = 1'b0;
          end
        end else if (req_byte_r == CH_SEMI || req_byte_r == CH_CR) begin
          if (cur_empty) begin
            status_nxt = ST_BAD;
            phase_nxt  = PH_DONE;
          end else begin
            phase_nxt = (req_byte_r == CH_SEMI) ? PH_EXT : PH_SIZE_LF;
          end
        end else begin
          status_nxt = ST_BAD;
          phase_nxt  = PH_DONE;
        end
      end
      PH_EXT: begin
        if (req_byte_r == CH_CR) begin
          phase_nxt = PH_EXT_LF;
        end
      end
      PH_EXT_LF, PH_SIZE_LF: begin
        if (req_byte_r != CH_LF) begin
          status_nxt = ST_BAD;
          phase_nxt  = PH_DONE;
        end else if (cur_remain != 32'd0) begin
          phase_nxt = PH_DATA;
        end else if (trailers_r) begin
          phase_nxt = PH_TRAILER;
          empty_nxt = 1'b1;
        end else begin
          phase_nxt = PH_FINAL_CR;
        end
      end
      PH_DATA: begin
        if (cur_count >= max_body_r) begin
          status_nxt = ST_BIG;
          phase_nxt  = PH_DONE;
        end else begin
          byte_nxt   = req_byte_r;
          bvalid_nxt = 1'b1;
          count_nxt  = cur_count + 32'd1;
          remain_nxt = remain_dec;
          if (remain_dec == 32'd0) begin
            phase_nxt = PH_DATA_CR;
          end
        end
      end
      PH_DATA_CR: begin
        if (req_byte_r == CH_CR) begin
          phase_nxt = PH_DATA_LF;
        end else begin
          status_nxt = ST_BAD;
          phase_nxt  = PH_DONE;
        end
      end
      PH_DATA_LF: begin
        if (req_byte_r == CH_LF) begin
          phase_nxt  = PH_SIZE;
          remain_nxt = '0;
          digits_nxt = '0;
          empty_nxt  = 1'b1;
        end else begin
          status_nxt = ST_BAD;
          phase_nxt  = PH_DONE;
        end
      end
      PH_TRAILER: begin
        if (req_byte_r == CH_CR) begin
          phase_nxt = PH_TRAILER_LF;
        end else begin
          empty_nxt = 1'b0;
        end
      end
      PH_TRAILER_LF: begin
        if (req_byte_r != CH_LF) begin
          status_nxt = ST_BAD;
          phase_nxt  = PH_DONE;
        end else if (cur_empty) begin
          status_nxt = ST_OK;
          phase_nxt  = PH_DONE;
        end else begin
          empty_nxt = 1'b1;
          phase_nxt = PH_TRAILER;
        end
      end
      PH_FINAL_CR: begin
        if (req_byte_r == CH_CR) begin
          phase_nxt = PH_FINAL_LF;
        end else begin
          status_nxt = ST_BAD;
          phase_nxt  = PH_DONE;
        end
      end
      PH_FINAL_LF: begin
        status_nxt = (req_byte_r == CH_LF) ? ST_OK : ST_BAD;
        phase_nxt  = PH_DONE;
      end
      default: begin
        // finished: bytes ignored until a new message
      end
    endcase
  end

  // Parser state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SIZE;
      remain_r <= '0;
      digits_r <= '0;
      count_r  <= '0;
      empty_r  <= 1'b1;
      status_r <= ST_RUN;
    end else if (advance) begin
      phase_r  <= phase_nxt;
      remain_r <= remain_nxt;
      digits_r <= digits_nxt;
      count_r  <= count_nxt;
      empty_r  <= empty_nxt;
      status_r <= status_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte_r   <= byte_nxt;
      out_bvalid_r <= bvalid_nxt;
      out_status_r <= status_nxt;
      out_len_r    <= count_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_body_valid  = out_bvalid_r;
  assign out_status      = out_status_r;
  assign out_body_length = out_len_r;

  // Checks
  a_done_iff_final: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DONE) == (status_r != ST_RUN))
    else $error("parser phase and final status disagree");

  a_body_only_running: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_bvalid_r) |-> (out_status_r == ST_RUN && out_len_r != 32'd0))
    else $error("body byte delivered with final status or zero length");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall && req_valid_r))
    else $error("request stalled without a held result");

  a_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !req_new_r && phase_r == PH_DATA && bvalid_nxt) |=>
      (count_r == $past(count_r) + 32'd1))
    else $error("body count did not step on a data byte");

endmodule
